// ===== src/ufb_pkg.sv =====
// ufb_pkg: shared constants and request/result payload types
package ufb_pkg;

  localparam int UFB_MAX_NODES = 256;
  localparam int NODE_W        = 8;
  localparam int NODE_SPAN     = 2 ** NODE_W;
  localparam int WEIGHT_W      = 32;
  localparam int CFG_W         = 9;
  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 9'd256;

  typedef struct packed {
    logic                start_req;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic                last_edge;
  } edge_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] bottleneck;
    logic                merged;
    logic                connected;
    logic                final_res;
  } result_item_t;

endpackage

// ===== src/ufb_edge_if.sv =====
// ufb_edge_if: valid/ready channel carrying one edge request
interface ufb_edge_if;
  logic                valid;
  logic                ready;
  ufb_pkg::edge_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/ufb_result_if.sv =====
// ufb_result_if: valid/ready channel carrying one result
interface ufb_result_if;
  logic                  valid;
  logic                  ready;
  ufb_pkg::result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/union_find_bottleneck_path.sv =====
// union_find_bottleneck_path: union-find bottleneck path engine over a parent memory
//
//   channel    | dir | handshake          | payload
//   edges      | in  | valid/ready        | start_req, edge_weight, node_a, node_b, last_edge
//   results    | out | valid/ready        | bottleneck, merged, connected, final_res
//   cfg        | in  | cfg_we, no wait    | node_count (9 bit)
//
// one request at a time; each root find is paced by the single read port
// of the parent memory, whose read data is registered
// a request takes 2 finds when 0 and 1 are already joined, else 6 finds
// start_req adds a clear sweep over node_count entries (held to 2..MAX_NODES)
// after reset a sweep over all MAX_NODES entries runs with edges.ready low
// a result waiting on results.ready holds the engine in its final step only
module union_find_bottleneck_path #(
  parameter int MAX_NODES = ufb_pkg::UFB_MAX_NODES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [ufb_pkg::CFG_W-1:0] cfg_wdata,
  ufb_edge_if.sink                 edges,
  ufb_result_if.source             results
);
  import ufb_pkg::*;

  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_CHK  = 6'b001000,
    S_GP   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef enum logic [5:0] {
    P_ROOT0  = 6'b000001,
    P_ROOT1  = 6'b000010,
    P_ROOTA  = 6'b000100,
    P_ROOTB  = 6'b001000,
    P_AFTER0 = 6'b010000,
    P_AFTER1 = 6'b100000
  } phase_t;

  state_t              state;
  phase_t              phase;
  logic [NW-1:0]       v;
  logic [NW-1:0]       root0;
  logic [NW-1:0]       ra;
  logic [CW-1:0]       clr_idx;
  logic [CW-1:0]       clr_lim;
  logic [CW-1:0]       clr_lim_next;
  logic                clr_to_rd;
  logic [WEIGHT_W-1:0] wt;
  logic [NW-1:0]       na;
  logic [NW-1:0]       nb;
  logic                last_q;
  logic [WEIGHT_W-1:0] bneck;
  logic                merged_q;
  logic                joined_q;
  logic [CFG_W-1:0]    node_count;

  logic [NW-1:0]       parent_mem [MAX_NODES];
  logic [NW-1:0]       rdata;
  logic [NW-1:0]       raddr;
  logic                we;
  logic [NW-1:0]       waddr;
  logic [NW-1:0]       wdata;

  logic [NW-1:0]       wrap_tab [NODE_SPAN];
  logic [CMP_W-1:0]    nc_ext;
  logic                root_hit;
  logic                accept;

  // node numbers wrap modulo the table depth
  for (genvar gi = 0; gi < NODE_SPAN; gi++) begin : g_wrap
    assign wrap_tab[gi] = NW'(gi % MAX_NODES);
  end

  assign edges.ready = (state == S_IDLE);
  assign accept      = edges.valid && edges.ready;
  assign root_hit    = (rdata == v);

  always_comb begin
    nc_ext = CMP_W'(node_count);
    if (nc_ext < CMP_W'(2)) begin
      clr_lim_next = CW'(2);
    end else if (nc_ext > CMP_W'(MAX_NODES)) begin
      clr_lim_next = CW'(MAX_NODES);
    end else begin
      clr_lim_next = CW'(nc_ext);
    end
  end

  // memory access control
  always_comb begin
    raddr = v;
    we    = 1'b0;
    waddr = v;
    wdata = rdata;
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_idx[NW-1:0];
        wdata = clr_idx[NW-1:0];
      end
      S_CHK: begin
        if (!root_hit) begin
          raddr = rdata;
        end else if (phase == P_ROOTB && ra != v) begin
          we    = 1'b1;
          waddr = ra;
          wdata = v;
        end
      end
      S_GP: begin
        // path halving: point v at its grandparent and carry on from there
        raddr = rdata;
        we    = 1'b1;
        waddr = v;
        wdata = rdata;
      end
      default: begin
        raddr = v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      parent_mem[waddr] <= wdata;
    end
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= parent_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      phase         <= P_ROOT0;
      clr_idx       <= '0;
      clr_lim       <= CW'(MAX_NODES);
      clr_to_rd     <= 1'b0;
      bneck         <= '0;
      results.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!results.valid || results.ready)) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + CW'(1);
          if (clr_idx == clr_lim - CW'(1)) begin
            state <= clr_to_rd ? S_RD : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            wt       <= edges.data.edge_weight;
            na       <= wrap_tab[edges.data.node_a];
            nb       <= wrap_tab[edges.data.node_b];
            last_q   <= edges.data.last_edge;
            merged_q <= 1'b0;
            phase    <= P_ROOT0;
            v        <= '0;
            if (edges.data.start_req) begin
              bneck     <= '0;
              clr_idx   <= '0;
              clr_lim   <= clr_lim_next;
              clr_to_rd <= 1'b1;
              state     <= S_CLR;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (!root_hit) begin
            state <= S_GP;
          end else begin
            state <= S_RD;
            case (phase)
              P_ROOT0: begin
                root0 <= v;
                v     <= NW'(1);
                phase <= P_ROOT1;
              end
              P_ROOT1: begin
                if (root0 == v) begin
                  joined_q <= 1'b1;
                  state    <= S_DONE;
                end else begin
                  v     <= na;
                  phase <= P_ROOTA;
                end
              end
              P_ROOTA: begin
                ra    <= v;
                v     <= nb;
                phase <= P_ROOTB;
              end
              P_ROOTB: begin
                if (ra != v) begin
                  merged_q <= 1'b1;
                  if (wt > bneck) begin
                    bneck <= wt;
                  end
                end
                v     <= '0;
                phase <= P_AFTER0;
              end
              P_AFTER0: begin
                root0 <= v;
                v     <= NW'(1);
                phase <= P_AFTER1;
              end
              P_AFTER1: begin
                joined_q <= (root0 == v);
                state    <= S_DONE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_GP: begin
          v     <= rdata;
          state <= S_CHK;
        end
        S_DONE: begin
          if (!results.valid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded as the request completes
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!results.valid || results.ready)) begin
      results.data.bottleneck <= bneck;
      results.data.merged     <= merged_q;
      results.data.connected  <= joined_q;
      results.data.final_res  <= last_q;
    end
  end

endmodule

// ===== src/ufb_checker.sv =====
// ufb_checker: port-level assertions for the bottleneck path engine, bound to the top level
module ufb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        edge_valid,
  input logic                        edge_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [ufb_pkg::WEIGHT_W+2:0] res_data
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed or dropped while stalled");

  // the clear sweep after reset keeps requests out
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !edge_ready)
    else $error("request taken during reset clear");

  // one request at a time: busy right after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    edge_valid && edge_ready |=> !edge_ready)
    else $error("second request taken back to back");

  // no result straight out of reset
  a_reset_no_result: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind union_find_bottleneck_path ufb_checker u_ufb_checker (
  .clk        (clk),
  .rst        (rst),
  .edge_valid (edges.valid),
  .edge_ready (edges.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_data   (results.data)
);
